>>> sv/prru_pkg.sv
// prru_pkg: types, field widths, action codes and the factorial table
// for the permutation rank / unrank unit; no dependencies
`timescale 1ns / 1ps

package prru_pkg;

	localparam int NIB_W       = 4;
	localparam int POS_N       = 16;
	localparam int PERM_W      = NIB_W * POS_N;
	localparam int RANK_W      = 45;
	localparam int ACT_W       = 2;
	localparam int SIZE_W      = 5;
	localparam int POS_W       = 4;
	localparam int SUB_W       = 2;
	localparam int IN_TDATA_W  = 120;
	localparam int OUT_TDATA_W = 112;
	localparam int OUT_TUSER_W = 1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd12;
	localparam logic [SIZE_W-1:0] SIZE_MIN   = 5'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RANK,
		ST_UNRANK,
		ST_FINISH
	} prru_state_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_RANK   = 2'd0,
		ACT_SWAP   = 2'd1,
		ACT_UNRANK = 2'd2,
		ACT_NONE   = 2'd3
	} prru_act_t;

	typedef logic [NIB_W-1:0] nib_t;

	// k! for k = 0..16
	function automatic logic [RANK_W-1:0] fact(input logic [SIZE_W-1:0] k);
		logic [RANK_W-1:0] f;
		case (k)
			5'd0:    f = 45'd1;
			5'd1:    f = 45'd1;
			5'd2:    f = 45'd2;
			5'd3:    f = 45'd6;
			5'd4:    f = 45'd24;
			5'd5:    f = 45'd120;
			5'd6:    f = 45'd720;
			5'd7:    f = 45'd5040;
			5'd8:    f = 45'd40320;
			5'd9:    f = 45'd362880;
			5'd10:   f = 45'd3628800;
			5'd11:   f = 45'd39916800;
			5'd12:   f = 45'd479001600;
			5'd13:   f = 45'd6227020800;
			5'd14:   f = 45'd87178291200;
			5'd15:   f = 45'd1307674368000;
			5'd16:   f = 45'd20922789888000;
			default: f = '0;
		endcase
		return f;
	endfunction

endpackage

>>> sv/permutation_rank_unrank_unit.sv
// permutation_rank_unrank_unit: lexicographic rank / unrank of permutations of
// up to 16 nibbles through the factorial number system
// depends on prru_pkg
`timescale 1ns / 1ps
// timing: rank and swap rank handle one position per step in ST_RANK; unrank makes
// four compare-subtract steps per position in ST_UNRANK in the one shared 48-bit
// subtractor; a too-big rank or an unused action goes straight to ST_FINISH
// throughput: one item at a time, the next is accepted once the result sits
// in the output register
// reset: asynchronous, active low; size register returns to 12, no result held

module permutation_rank_unrank_unit #(
	parameter int MAX_SIZE = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// size register write
	input  logic                               cfg_we,
	input  logic [prru_pkg::SIZE_W-1:0]        cfg_wdata,
	// input items
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// perm [63:0], rank_in [108:64], swap_first [112:109], swap_second [116:113]
	input  logic [prru_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// action [1:0]
	input  logic [prru_pkg::ACT_W-1:0]         s_axis_tuser,
	// result items
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// rank_out [44:0], perm_out [108:45]
	output logic [prru_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// rank_too_big [0]
	output logic [prru_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

	import prru_pkg::*;

	localparam logic [SIZE_W-1:0] MaxN = SIZE_W'(MAX_SIZE);

	// control state
	prru_state_t       state_q, state_nxt;
	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] rem_q;     // positions still to do, counts down to 1
	logic [POS_W-1:0]  pos_q;     // output position for unrank
	logic [SUB_W-1:0]  sub_q;     // digit bit under trial, 3 down to 0
	logic              out_valid_q;

	// working payload
	logic [PERM_W-1:0] work_q;    // rank: values shifted down; unrank: free list
	logic [PERM_W-1:0] permw_q;   // unranked permutation being built
	logic [RANK_W-1:0] acc_q;     // rank accumulator
	logic [RANK_W-1:0] term_q;    // product of the previous position
	logic [RANK_W-1:0] r_q;       // unrank remainder
	logic [NIB_W-1:0]  digit_q;
	logic              big_q;

	// output register
	logic [RANK_W-1:0] rank_out_q;
	logic [PERM_W-1:0] perm_out_q;
	logic              big_out_q;

	// handshake decode
	logic in_fire;
	logic out_load;

	// effective size, clamped into 2..MAX_SIZE
	logic [SIZE_W-1:0] n_eff;
	always_comb begin
		if (size_q < SIZE_MIN) begin
			n_eff = SIZE_MIN;
		end else if (size_q > MaxN) begin
			n_eff = MaxN;
		end else begin
			n_eff = size_q;
		end
	end

	// input fields
	logic [PERM_W-1:0] in_perm;
	logic [RANK_W-1:0] in_rank;
	logic [POS_W-1:0]  in_swap_a;
	logic [POS_W-1:0]  in_swap_b;
	prru_act_t         in_act;

	assign in_perm   = s_axis_tdata[PERM_W-1:0];
	assign in_rank   = s_axis_tdata[PERM_W +: RANK_W];
	assign in_swap_a = s_axis_tdata[PERM_W+RANK_W +: POS_W];
	assign in_swap_b = s_axis_tdata[PERM_W+RANK_W+POS_W +: POS_W];
	assign in_act    = prru_act_t'(s_axis_tuser);

	// mask nibbles at and above n, then the optional exchange
	nib_t              mask_nib [POS_N];
	nib_t              nib_a;
	nib_t              nib_b;
	logic [PERM_W-1:0] load_vec;
	always_comb begin
		for (int k = 0; k < POS_N; k++) begin
			mask_nib[k] = (SIZE_W'(k) < n_eff) ? in_perm[NIB_W*k +: NIB_W] : '0;
		end
		nib_a = mask_nib[in_swap_a];
		nib_b = mask_nib[in_swap_b];
		for (int k = 0; k < POS_N; k++) begin
			if (in_act == ACT_SWAP && POS_W'(k) == in_swap_b) begin
				load_vec[NIB_W*k +: NIB_W] = nib_a;
			end else if (in_act == ACT_SWAP && POS_W'(k) == in_swap_a) begin
				load_vec[NIB_W*k +: NIB_W] = nib_b;
			end else begin
				load_vec[NIB_W*k +: NIB_W] = mask_nib[k];
			end
		end
	end

	logic too_big_in;
	assign too_big_in = (in_rank >= fact(n_eff));

	// factorial of the positions after the current one, shared by both directions
	logic [RANK_W-1:0] f_cur;
	assign f_cur = fact(SIZE_W'(rem_q - 5'd1));

	// rank step: count later valid values below the current one
	logic [POS_N-2:0]    lt_vec;
	logic [NIB_W-1:0]    cnt;
	logic [RANK_W+3:0]   prod;
	always_comb begin
		for (int k = 1; k < POS_N; k++) begin
			lt_vec[k-1] = (SIZE_W'(k) < rem_q) &&
				(work_q[NIB_W*k +: NIB_W] < work_q[NIB_W-1:0]);
		end
		cnt  = NIB_W'($countones(lt_vec));
		prod = {{RANK_W{1'b0}}, cnt} * {{NIB_W{1'b0}}, f_cur};
	end

	// unrank step: one trial subtract of f << sub per cycle
	logic [RANK_W+2:0] trial;
	logic              ge;
	logic [RANK_W+2:0] r_diff;
	logic [NIB_W-1:0]  d_now;
	nib_t              pick;
	logic [PERM_W-1:0] list_nxt;
	always_comb begin
		trial  = {3'b000, f_cur} << sub_q;
		ge     = ({3'b000, r_q} >= trial);
		r_diff = {3'b000, r_q} - trial;
		d_now  = digit_q;
		d_now[sub_q] = ge;
		pick   = work_q[NIB_W*d_now +: NIB_W];
		// drop the picked entry from the free list
		for (int k = 0; k < POS_N; k++) begin
			if (NIB_W'(k) < d_now) begin
				list_nxt[NIB_W*k +: NIB_W] = work_q[NIB_W*k +: NIB_W];
			end else if (k < POS_N - 1) begin
				list_nxt[NIB_W*k +: NIB_W] = work_q[NIB_W*(k+1) +: NIB_W];
			end else begin
				list_nxt[NIB_W*k +: NIB_W] = '0;
			end
		end
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		in_fire       = s_axis_tvalid && (state_q == ST_IDLE);
		out_load      = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
	end

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (in_act) inside
						ACT_RANK, ACT_SWAP: state_nxt = ST_RANK;
						ACT_UNRANK:         state_nxt = too_big_in ? ST_FINISH : ST_UNRANK;
						default:            state_nxt = ST_FINISH;
					endcase
				end
			end
			ST_RANK: begin
				if (rem_q == 5'd1) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_UNRANK: begin
				if (sub_q == '0 && rem_q == 5'd1) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= SIZE_RESET;
			rem_q       <= '0;
			pos_q       <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			if (in_fire) begin
				rem_q <= n_eff;
				pos_q <= '0;
				sub_q <= SUB_W'(3);
			end else if (state_q == ST_RANK) begin
				rem_q <= rem_q - 5'd1;
			end else if (state_q == ST_UNRANK) begin
				sub_q <= sub_q - 2'd1;
				if (sub_q == '0) begin
					rem_q <= rem_q - 5'd1;
					pos_q <= pos_q + 4'd1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			acc_q   <= '0;
			term_q  <= '0;
			r_q     <= in_rank;
			digit_q <= '0;
			permw_q <= '0;
			big_q   <= (in_act == ACT_UNRANK) && too_big_in;
			if (in_act == ACT_UNRANK) begin
				// free list starts as 0, 1, 2, ...
				for (int k = 0; k < POS_N; k++) begin
					work_q[NIB_W*k +: NIB_W] <= NIB_W'(k);
				end
			end else begin
				work_q <= load_vec;
			end
		end else if (state_q == ST_RANK) begin
			acc_q  <= acc_q + term_q;
			term_q <= prod[RANK_W-1:0];
			work_q <= {{NIB_W{1'b0}}, work_q[PERM_W-1:NIB_W]};
		end else if (state_q == ST_UNRANK) begin
			if (ge) begin
				r_q <= r_diff[RANK_W-1:0];
			end
			if (sub_q == '0) begin
				digit_q <= '0;
				work_q  <= list_nxt;
				permw_q[NIB_W*pos_q +: NIB_W] <= pick;
			end else begin
				digit_q <= d_now;
			end
		end
		if (out_load) begin
			rank_out_q <= acc_q;
			perm_out_q <= permw_q;
			big_out_q  <= big_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-PERM_W-RANK_W){1'b0}}, perm_out_q, rank_out_q};
	assign m_axis_tuser  = big_out_q;

endmodule
